@@ rtl/tcce_pkg.sv @@
// ----------------------------------------------------------------------------
// tcce_pkg: shared types and constants of the text console cell engine
// Command kinds, register indexes, sequencer states and cell layout.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // Command kinds carried by one input beat
    localparam logic [1:0] KIND_PRINT = 2'd0;
    localparam logic [1:0] KIND_SETCUR = 2'd1;
    localparam logic [1:0] KIND_PUT = 2'd2;
    localparam logic [1:0] KIND_READ = 2'd3;

    // Configuration register port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [6:0] ROWS_RESET = 7'd25;

    // Width of the row and column compare arithmetic (holds up to 511)
    localparam int CMP_W = 9;

    // Cell layout: code in [7:0], foreground in [11:8], background in [15:12]
    localparam int CELL_W = 16;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

    // Sequencer states
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CLEAR  = 6'b000010,
        ST_RDWAIT = 6'b000100,
        ST_SCRD   = 6'b001000,
        ST_SCWR   = 6'b010000,
        ST_BLANK  = 6'b100000
    } t_state;

endpackage

@@ rtl/tcce_cell_ram.sv @@
// ----------------------------------------------------------------------------
// tcce_cell_ram: character cell store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcce_cell_ram #(
    parameter int DEPTH = 8192,
    parameter int ADDR_W = 13,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write one cell
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/text_console_cell_engine_top.sv @@
// ----------------------------------------------------------------------------
// text_console_cell_engine_top: character-cell text console with scroll-up
// Keeps a cell store and a cursor; prints, sets the cursor, puts and reads
// cells, and scrolls the region in use up one row past the last row.
//
//   channel   direction  handshake                 payload
//   command   in         start high, busy low      kind, char, row, col, colours
//   result    out        o_result_valid, 1 cycle   cursor, scrolls, cell, bad
//   config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A print or a set cursor without scroll, a put and a read of a bad position
// leave the engine idle: the next command may start in the cycle the result is shown.
// A read in range passes through ST_RDWAIT (registered read of the cell store port).
// Each scroll walks the cell store through its one read and one write port: a read
// and a write per cell of the rows below the top, then a blanking write per bottom cell.
// After reset a clearing pass writes all MAX_ROWS*MAX_COLS cells, one a cycle,
// with busy high; config writes are taken meanwhile. The receiver cannot stall.
// ----------------------------------------------------------------------------
module text_console_cell_engine_top
    import tcce_pkg::*;
#(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_kind,
    input  logic [7:0]            i_char_code,
    input  logic [6:0]            i_pos_row,
    input  logic [6:0]            i_pos_col,
    input  logic [3:0]            i_back_color,
    input  logic [3:0]            i_fore_color,
    output logic                  o_result_valid,
    output logic [5:0]            o_cursor_row,
    output logic [6:0]            o_cursor_col,
    output logic [6:0]            o_scroll_count,
    output logic [7:0]            o_cell_code,
    output logic [3:0]            o_cell_fore,
    output logic [3:0]            o_cell_back,
    output logic                  o_bad_position
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int NCNT_W = $clog2(MAX_ROWS + 1);
    localparam int PROD_W = 2 * CMP_W;

    // Row-major address with a fixed stride of MAX_COLS
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [CMP_W-1:0] row,
                                                     input logic [CMP_W-1:0] col);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(row) * PROD_W'(MAX_COLS) + PROD_W'(col);
        return ADDR_W'(prod);
    endfunction

    t_state r_state, n_state;
    logic [7:0]         r_cols_cfg;
    logic [6:0]         r_rows_cfg;
    logic [ROW_W-1:0]   r_cur_row, n_cur_row;
    logic [COL_W-1:0]   r_cur_col, n_cur_col;
    logic [ROW_W-1:0]   r_sr, n_sr;
    logic [COL_W-1:0]   r_sc, n_sc;
    logic [NCNT_W-1:0]  r_nleft, n_nleft;
    logic [ADDR_W-1:0]  r_clr, n_clr;
    logic               r_valid, n_valid;
    logic [5:0]         r_out_row, n_out_row;
    logic [6:0]         r_out_col, n_out_col;
    logic [6:0]         r_out_scr, n_out_scr;
    logic [CELL_W-1:0]  r_out_cell, n_out_cell;
    logic               r_out_bad, n_out_bad;

    logic [CMP_W-1:0]   rows9, cols9, last_row9, last_col9;
    logic [CMP_W-1:0]   crow9, ccol9, prow9, pcol9, nrow9, ncol9, scr9;
    logic               accept, pos_bad;
    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [CELL_W-1:0]  ram_wdata, ram_rdata;

    // Effective region in use: zero acts as one, excess acts as the maximum
    always_comb begin
        if (r_rows_cfg == 7'd0) begin
            rows9 = CMP_W'(1);
        end else if (CMP_W'(r_rows_cfg) > CMP_W'(MAX_ROWS)) begin
            rows9 = CMP_W'(MAX_ROWS);
        end else begin
            rows9 = CMP_W'(r_rows_cfg);
        end
        if (r_cols_cfg == 8'd0) begin
            cols9 = CMP_W'(1);
        end else if (CMP_W'(r_cols_cfg) > CMP_W'(MAX_COLS)) begin
            cols9 = CMP_W'(MAX_COLS);
        end else begin
            cols9 = CMP_W'(r_cols_cfg);
        end
        last_row9 = rows9 - CMP_W'(1);
        last_col9 = cols9 - CMP_W'(1);
    end

    // Clamp a stale cursor; extend the command position
    always_comb begin
        crow9 = (CMP_W'(r_cur_row) >= rows9) ? last_row9 : CMP_W'(r_cur_row);
        ccol9 = (CMP_W'(r_cur_col) >= cols9) ? last_col9 : CMP_W'(r_cur_col);
        prow9 = CMP_W'(i_pos_row);
        pcol9 = CMP_W'(i_pos_col);
        pos_bad = (prow9 >= rows9) || (pcol9 >= cols9);
    end

    assign accept = start && (r_state == ST_IDLE);
    assign busy = (r_state != ST_IDLE);

    // Sequencer and shared cell store port
    always_comb begin
        n_state = r_state;
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        n_sr = r_sr;
        n_sc = r_sc;
        n_nleft = r_nleft;
        n_clr = r_clr;
        n_valid = 1'b0;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        n_out_scr = r_out_scr;
        n_out_cell = r_out_cell;
        n_out_bad = r_out_bad;
        nrow9 = crow9;
        ncol9 = ccol9;
        scr9 = '0;
        ram_we = 1'b0;
        ram_waddr = '0;
        ram_wdata = BLANK_CELL;
        ram_re = 1'b0;
        ram_raddr = cell_addr(CMP_W'(r_sr) + CMP_W'(1), CMP_W'(r_sc));

        unique case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                ram_waddr = r_clr;
                if (r_clr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + ADDR_W'(1);
                end
            end

            ST_IDLE: begin
                if (accept) begin
                    n_out_cell = '0;
                    n_out_bad = 1'b0;
                    n_out_row = 6'(r_cur_row);
                    n_out_col = 7'(r_cur_col);
                    n_valid = 1'b1;
                    case (i_kind)
                        KIND_PRINT: begin
                            if (i_char_code == NEWLINE_CODE) begin
                                nrow9 = crow9 + CMP_W'(1);
                                ncol9 = '0;
                            end else begin
                                ram_we = 1'b1;
                                ram_waddr = cell_addr(crow9, ccol9);
                                ram_wdata = {i_back_color, i_fore_color, i_char_code};
                                if (ccol9 + CMP_W'(1) >= cols9) begin
                                    nrow9 = crow9 + CMP_W'(1);
                                    ncol9 = '0;
                                end else begin
                                    ncol9 = ccol9 + CMP_W'(1);
                                end
                            end
                            if (nrow9 >= rows9) begin
                                nrow9 = last_row9;
                                scr9 = CMP_W'(1);
                            end
                        end
                        KIND_SETCUR: begin
                            nrow9 = prow9;
                            ncol9 = (pcol9 >= cols9) ? last_col9 : pcol9;
                            if (prow9 >= rows9) begin
                                scr9 = prow9 - last_row9;
                                nrow9 = last_row9;
                            end
                        end
                        KIND_PUT: begin
                            nrow9 = CMP_W'(r_cur_row);
                            ncol9 = CMP_W'(r_cur_col);
                            n_out_bad = pos_bad;
                            if (!pos_bad) begin
                                ram_we = 1'b1;
                                ram_waddr = cell_addr(prow9, pcol9);
                                ram_wdata = {i_back_color, i_fore_color, i_char_code};
                            end
                        end
                        default: begin
                            nrow9 = CMP_W'(r_cur_row);
                            ncol9 = CMP_W'(r_cur_col);
                            n_out_bad = pos_bad;
                            if (!pos_bad) begin
                                ram_re = 1'b1;
                                ram_raddr = cell_addr(prow9, pcol9);
                                n_valid = 1'b0;
                                n_state = ST_RDWAIT;
                            end
                        end
                    endcase
                    n_cur_row = ROW_W'(nrow9);
                    n_cur_col = COL_W'(ncol9);
                    n_out_row = 6'(nrow9);
                    n_out_col = 7'(ncol9);
                    n_out_scr = 7'(scr9);
                    // Start the scroll walk; extra scrolls past a full screen change nothing
                    if (scr9 != '0) begin
                        n_valid = 1'b0;
                        n_nleft = NCNT_W'((scr9 < rows9) ? scr9 : rows9);
                        n_sr = '0;
                        n_sc = '0;
                        n_state = (rows9 == CMP_W'(1)) ? ST_BLANK : ST_SCRD;
                    end
                end
            end

            ST_RDWAIT: begin
                n_out_cell = ram_rdata;
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end

            ST_SCRD: begin
                ram_re = 1'b1;
                n_state = ST_SCWR;
            end

            ST_SCWR: begin
                // Copy the cell of the row below into this row
                ram_we = 1'b1;
                ram_waddr = cell_addr(CMP_W'(r_sr), CMP_W'(r_sc));
                ram_wdata = ram_rdata;
                n_state = ST_SCRD;
                if (CMP_W'(r_sc) == last_col9) begin
                    n_sc = '0;
                    if (CMP_W'(r_sr) + CMP_W'(2) == rows9) begin
                        n_state = ST_BLANK;
                    end else begin
                        n_sr = r_sr + ROW_W'(1);
                    end
                end else begin
                    n_sc = r_sc + COL_W'(1);
                end
            end

            ST_BLANK: begin
                // Blank the bottom row
                ram_we = 1'b1;
                ram_waddr = cell_addr(last_row9, CMP_W'(r_sc));
                ram_wdata = BLANK_CELL;
                if (CMP_W'(r_sc) == last_col9) begin
                    n_sc = '0;
                    n_sr = '0;
                    if (r_nleft == NCNT_W'(1)) begin
                        n_valid = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_nleft = r_nleft - NCNT_W'(1);
                        n_state = (rows9 == CMP_W'(1)) ? ST_BLANK : ST_SCRD;
                    end
                end else begin
                    n_sc = r_sc + COL_W'(1);
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cols_cfg <= COLS_RESET;
            r_rows_cfg <= ROWS_RESET;
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_sr <= '0;
            r_sc <= '0;
            r_nleft <= '0;
            r_clr <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
            r_sr <= n_sr;
            r_sc <= n_sc;
            r_nleft <= n_nleft;
            r_clr <= n_clr;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COLS: r_cols_cfg <= i_cfg_data;
                    CFG_ROWS: r_rows_cfg <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    // Result beat payload
    always_ff @(posedge i_clk) begin
        r_out_row <= n_out_row;
        r_out_col <= n_out_col;
        r_out_scr <= n_out_scr;
        r_out_cell <= n_out_cell;
        r_out_bad <= n_out_bad;
    end

    tcce_cell_ram #(
        .DEPTH(DEPTH),
        .ADDR_W(ADDR_W),
        .DATA_W(CELL_W)
    ) u_ram (
        .i_clk(i_clk),
        .i_we(ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re(ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_result_valid = r_valid;
    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;
    assign o_scroll_count = r_out_scr;
    assign o_cell_code = r_out_cell[7:0];
    assign o_cell_fore = r_out_cell[11:8];
    assign o_cell_back = r_out_cell[15:12];
    assign o_bad_position = r_out_bad;

endmodule

@@ rtl/tcce_checker.sv @@
// ----------------------------------------------------------------------------
// tcce_checker: port-level checks of the text console cell engine
// Watches command and result beats on the top level ports.
// ----------------------------------------------------------------------------
module tcce_checker
    import tcce_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [1:0]            i_kind,
    input logic                  o_result_valid,
    input logic [6:0]            o_scroll_count,
    input logic [7:0]            o_cell_code,
    input logic [3:0]            o_cell_fore,
    input logic [3:0]            o_cell_back,
    input logic                  o_bad_position
);

    // Reset starts the clearing pass, so no command is taken right after it
    a_clear_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // A result beat only appears once the engine has gone idle
    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result beat while busy");

    // A put shows its result beat in the next cycle
    a_put_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == KIND_PUT) |=> o_result_valid)
        else $error("put result missing");

    // A bad position reports no scroll and no cell contents
    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_bad_position) |->
            (o_scroll_count == 7'd0 && o_cell_code == 8'd0 &&
             o_cell_fore == 4'd0 && o_cell_back == 4'd0))
        else $error("bad position with payload");

endmodule

bind text_console_cell_engine_top tcce_checker u_checker (.*);

@@ tb/tcce_result_checker.sv @@
// ----------------------------------------------------------------------------
// tcce_result_checker: prediction and checking for the text console engine
// Watches the config port, the command channel and the result strobe. Keeps
// its own cell store, cursor and geometry, predicts one result beat for every
// accepted command and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tcce_result_checker
    import tcce_pkg::*;
#(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [1:0]            i_kind,
    input  logic [7:0]            i_char_code,
    input  logic [6:0]            i_pos_row,
    input  logic [6:0]            i_pos_col,
    input  logic [3:0]            i_back_color,
    input  logic [3:0]            i_fore_color,
    input  logic                  i_result_valid,
    input  logic [5:0]            i_cursor_row,
    input  logic [6:0]            i_cursor_col,
    input  logic [6:0]            i_scroll_count,
    input  logic [7:0]            i_cell_code,
    input  logic [3:0]            i_cell_fore,
    input  logic [3:0]            i_cell_back,
    input  logic                  i_bad_position,
    output logic [31:0]           o_fail_count,
    output logic [31:0]           o_pending,
    output logic [31:0]           o_checked,
    output logic [31:0]           o_scrolls
);

    localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;

    // One result beat, tagged with the kind of command that caused it
    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] row;
        logic [6:0] col;
        logic [6:0] scrolls;
        logic [7:0] code;
        logic [3:0] fore;
        logic [3:0] back;
        logic       bad;
    } t_console_beat;

    logic [CELL_W-1:0] cell_mirror [STORE_DEPTH];
    int unsigned       mirror_row = 0;
    int unsigned       mirror_col = 0;
    logic [7:0]        cols_setting = COLS_RESET;
    logic [6:0]        rows_setting = ROWS_RESET;
    t_console_beat     expected_beats [$];
    t_console_beat     want_beat;
    t_console_beat     seen_beat;
    int                fail_count = 0;
    int                pending_count = 0;
    int                checked_count = 0;
    int                scroll_total = 0;

    assign o_fail_count = fail_count;
    assign o_pending = pending_count;
    assign o_checked = checked_count;
    assign o_scrolls = scroll_total;

    // Zero acts as one, anything past the store acts as the store size
    function automatic int unsigned cols_active();
        if (cols_setting == 0) return 1;
        if (cols_setting > MAX_COLS) return MAX_COLS;
        return 32'(cols_setting);
    endfunction

    function automatic int unsigned rows_active();
        if (rows_setting == 0) return 1;
        if (rows_setting > MAX_ROWS) return MAX_ROWS;
        return 32'(rows_setting);
    endfunction

    // Fixed stride of the store, independent of the columns in use
    function automatic int unsigned cell_at(int unsigned row, int unsigned col);
        return (row * MAX_COLS + col) % STORE_DEPTH;
    endfunction

    // Move the region in use up one row and blank its bottom row
    function automatic void shift_region_up();
        int unsigned nr;
        int unsigned nc;
        nr = rows_active();
        nc = cols_active();
        for (int unsigned r = 0; r + 1 < nr; r++)
            for (int unsigned c = 0; c < nc; c++)
                cell_mirror[cell_at(r, c)] = cell_mirror[cell_at(r + 1, c)];
        for (int unsigned c = 0; c < nc; c++)
            cell_mirror[cell_at(nr - 1, c)] = BLANK_CELL;
    endfunction

    // Apply one command to the mirror and work out the beat it must produce
    function automatic t_console_beat predict_beat(
        logic [1:0] kind, logic [7:0] code, logic [6:0] row_in, logic [6:0] col_in,
        logic [3:0] back, logic [3:0] fore
    );
        int unsigned       nr;
        int unsigned       nc;
        int unsigned       prow;
        int unsigned       pcol;
        int unsigned       excess;
        int unsigned       sweeps;
        logic [CELL_W-1:0] readv;
        t_console_beat     beat;
        nr = rows_active();
        nc = cols_active();
        prow = 32'(row_in);
        pcol = 32'(col_in);
        excess = 0;
        readv = '0;
        beat = '0;
        beat.kind = kind;
        case (kind)
            KIND_PRINT: begin
                // clamp a cursor left stale by a smaller geometry
                if (mirror_row >= nr) mirror_row = nr - 1;
                if (mirror_col >= nc) mirror_col = nc - 1;
                if (code == NEWLINE_CODE) begin
                    mirror_col = 0;
                    mirror_row++;
                end else begin
                    cell_mirror[cell_at(mirror_row, mirror_col)] = {back, fore, code};
                    mirror_col++;
                    if (mirror_col >= nc) begin
                        mirror_col = 0;
                        mirror_row++;
                    end
                end
                if (mirror_row >= nr) begin
                    mirror_row = nr - 1;
                    shift_region_up();
                    excess = 1;
                end
            end
            KIND_SETCUR: begin
                // rows past the bottom are scrolled; more than a screen changes nothing
                if (prow >= nr) begin
                    excess = prow - (nr - 1);
                    sweeps = (excess < nr) ? excess : nr;
                    repeat (sweeps) shift_region_up();
                    prow = nr - 1;
                end
                if (pcol >= nc) pcol = nc - 1;
                mirror_row = prow;
                mirror_col = pcol;
            end
            default: begin
                if (prow >= nr || pcol >= nc) begin
                    beat.bad = 1'b1;
                end else if (kind == KIND_PUT) begin
                    cell_mirror[cell_at(prow, pcol)] = {back, fore, code};
                end else begin
                    readv = cell_mirror[cell_at(prow, pcol)];
                end
            end
        endcase
        beat.row = mirror_row[5:0];
        beat.col = mirror_col[6:0];
        beat.scrolls = excess[6:0];
        beat.code = readv[7:0];
        beat.fore = readv[11:8];
        beat.back = readv[15:12];
        scroll_total += excess;
        return beat;
    endfunction

    // Track the block edge by edge: config, then result beat, then new command
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_DEPTH; i++) cell_mirror[i] = BLANK_CELL;
            mirror_row = 0;
            mirror_col = 0;
            cols_setting = COLS_RESET;
            rows_setting = ROWS_RESET;
            expected_beats.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_COLS) cols_setting = i_cfg_data;
                else if (i_cfg_idx == CFG_ROWS) rows_setting = i_cfg_data[6:0];
            end
            if (i_result_valid) begin
                seen_beat = {2'b00, i_cursor_row, i_cursor_col, i_scroll_count,
                             i_cell_code, i_cell_fore, i_cell_back, i_bad_position};
                if (expected_beats.size() == 0) begin
                    fail_count++;
                    $display("%0t: expected no result beat, actual %p",
                             $time, seen_beat);
                end else begin
                    want_beat = expected_beats.pop_front();
                    seen_beat.kind = want_beat.kind;
                    checked_count++;
                    if (seen_beat !== want_beat) begin
                        fail_count++;
                        $display("%0t: mismatch on kind %0d command", $time,
                                 want_beat.kind);
                        $display("    expected row %0d col %0d scr %0d cell %h/%0d/%0d bad %b",
                                 want_beat.row, want_beat.col, want_beat.scrolls,
                                 want_beat.code, want_beat.fore, want_beat.back,
                                 want_beat.bad);
                        $display("    actual   row %0d col %0d scr %0d cell %h/%0d/%0d bad %b",
                                 seen_beat.row, seen_beat.col, seen_beat.scrolls,
                                 seen_beat.code, seen_beat.fore, seen_beat.back,
                                 seen_beat.bad);
                    end
                end
            end
            if (i_start && !i_busy) begin
                expected_beats.push_back(predict_beat(i_kind, i_char_code, i_pos_row,
                                                      i_pos_col, i_back_color,
                                                      i_fore_color));
            end
        end
        pending_count = expected_beats.size();
    end

endmodule

@@ tb/tb_text_console_cell_engine_top.sv @@
// ----------------------------------------------------------------------------
// tb_text_console_cell_engine_top: testbench of the text console cell engine
// Drives directed commands at the field and geometry extremes, then phases of
// random commands under random geometries with random sender gaps. A checker
// beside the block predicts every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_text_console_cell_engine_top;
    import tcce_pkg::*;

    localparam int MAX_COLS = 128;
    localparam int MAX_ROWS = 64;
    localparam int RANDOM_ITEMS = 1300;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 50;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  start;
    logic                  busy;
    logic [1:0]            i_kind;
    logic [7:0]            i_char_code;
    logic [6:0]            i_pos_row;
    logic [6:0]            i_pos_col;
    logic [3:0]            i_back_color;
    logic [3:0]            i_fore_color;
    logic                  o_result_valid;
    logic [5:0]            o_cursor_row;
    logic [6:0]            o_cursor_col;
    logic [6:0]            o_scroll_count;
    logic [7:0]            o_cell_code;
    logic [3:0]            o_cell_fore;
    logic [3:0]            o_cell_back;
    logic                  o_bad_position;

    logic [31:0] fail_count;
    logic [31:0] pending;
    logic [31:0] checked;
    logic [31:0] scrolls;

    longint      cycle_count = 0;
    longint      cycle_budget = 200_000;
    int unsigned cols_now = 32'(COLS_RESET);
    int unsigned rows_now = 32'(ROWS_RESET);
    int          kind_sent [4] = '{0, 0, 0, 0};
    int          geometries = 1;

    text_console_cell_engine_top #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_char_code    (i_char_code),
        .i_pos_row      (i_pos_row),
        .i_pos_col      (i_pos_col),
        .i_back_color   (i_back_color),
        .i_fore_color   (i_fore_color),
        .o_result_valid (o_result_valid),
        .o_cursor_row   (o_cursor_row),
        .o_cursor_col   (o_cursor_col),
        .o_scroll_count (o_scroll_count),
        .o_cell_code    (o_cell_code),
        .o_cell_fore    (o_cell_fore),
        .o_cell_back    (o_cell_back),
        .o_bad_position (o_bad_position)
    );

    tcce_result_checker #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_start        (start),
        .i_busy         (busy),
        .i_kind         (i_kind),
        .i_char_code    (i_char_code),
        .i_pos_row      (i_pos_row),
        .i_pos_col      (i_pos_col),
        .i_back_color   (i_back_color),
        .i_fore_color   (i_fore_color),
        .i_result_valid (o_result_valid),
        .i_cursor_row   (o_cursor_row),
        .i_cursor_col   (o_cursor_col),
        .i_scroll_count (o_scroll_count),
        .i_cell_code    (o_cell_code),
        .i_cell_fore    (o_cell_fore),
        .i_cell_back    (o_cell_back),
        .i_bad_position (o_bad_position),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_scrolls      (scrolls)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Stop the run once it overshoots the cycles its commands could need
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_budget) begin
            $display("Run stopped at cycle %0d, past its limit of %0d", cycle_count,
                     cycle_budget);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offer one command beat and hold it until the block takes it
    task automatic send_command(
        input logic [1:0] kind, input logic [7:0] code, input logic [6:0] row,
        input logic [6:0] col, input logic [3:0] back, input logic [3:0] fore
    );
        longint      sweep;
        int unsigned sweeps;
        sweep = longint'(2 * (rows_now - 1) * cols_now + cols_now);
        sweeps = 0;
        if (kind == KIND_PRINT) sweeps = 1;
        else if (kind == KIND_SETCUR && row >= rows_now)
            sweeps = (row - rows_now + 1 < rows_now) ? row - rows_now + 1 : rows_now;
        cycle_budget += 4 * (4 + sweeps * sweep);
        start <= 1'b1;
        i_kind <= kind;
        i_char_code <= code;
        i_pos_row <= row;
        i_pos_col <= col;
        i_back_color <= back;
        i_fore_color <= fore;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        kind_sent[kind]++;
    endtask

    // Idle the sender for a random gap: mostly none or short, a few long
    task automatic pause_sender(input bit burst);
        int unsigned pick;
        int unsigned gap;
        pick = $urandom_range(0, 99);
        if (burst || pick < 60) gap = 0;
        else if (pick < 88) gap = $urandom_range(1, 3);
        else if (pick < 97) gap = $urandom_range(4, 12);
        else gap = $urandom_range(20, 45);
        if (gap > 0) begin
            cycle_budget += gap;
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop start and wait until every result beat is in and the block is idle
    task automatic wait_for_idle();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both geometry registers, optionally poking the spare indexes first
    task automatic set_geometry(
        input logic [7:0] cols_data, input logic [7:0] rows_data, input bit with_spare
    );
        cycle_budget += 100;
        wait_for_idle();
        i_cfg_we <= 1'b1;
        if (with_spare) begin
            i_cfg_idx <= CFG_IDX_W'(2);
            i_cfg_data <= 8'($urandom_range(0, 255));
            @(posedge i_clk);
            i_cfg_idx <= CFG_IDX_W'(3);
            i_cfg_data <= 8'($urandom_range(0, 255));
            @(posedge i_clk);
        end
        i_cfg_idx <= CFG_COLS;
        i_cfg_data <= cols_data;
        @(posedge i_clk);
        i_cfg_idx <= CFG_ROWS;
        i_cfg_data <= rows_data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cols_now = (cols_data == 0) ? 1 :
                   (cols_data > MAX_COLS ? MAX_COLS : 32'(cols_data));
        rows_now = (rows_data[6:0] == 0) ? 1 :
                   (rows_data[6:0] > MAX_ROWS ? MAX_ROWS : 32'(rows_data[6:0]));
        geometries++;
    endtask

    // One random command, mostly aimed inside the region in use
    task automatic send_random_command(input bit roomy);
        int unsigned pick;
        logic [1:0]  kind;
        logic [7:0]  code;
        logic [6:0]  row;
        logic [6:0]  col;
        pick = $urandom_range(0, 99);
        code = 8'($urandom_range(0, 255));
        row = 7'($urandom_range(0, rows_now - 1));
        col = 7'($urandom_range(0, cols_now - 1));
        if (pick < 45) begin
            kind = KIND_PRINT;
            if ($urandom_range(0, 99) < (roomy ? 5 : 12)) code = NEWLINE_CODE;
        end else if (pick < 60) begin
            kind = KIND_SETCUR;
            // keep big screens clear of multi-row scrolls
            if (!roomy && $urandom_range(0, 3) == 0) row = 7'($urandom_range(0, 127));
            if ($urandom_range(0, 4) == 0) col = 7'($urandom_range(0, 127));
        end else begin
            kind = (pick < 78) ? KIND_PUT : KIND_READ;
            if ($urandom_range(0, 6) == 0) row = 7'($urandom_range(0, 127));
            if ($urandom_range(0, 6) == 0) col = 7'($urandom_range(0, 127));
        end
        send_command(kind, code, row, col, 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)));
    endtask

    // Stimulus and verdict
    initial begin
        int          random_sent;
        int unsigned pick;
        int unsigned phase_len;
        bit          roomy;
        bit          burst;
        logic [7:0]  cols_data;
        logic [7:0]  rows_data;
        random_sent = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_COLS;
        i_cfg_data <= '0;
        start <= 1'b0;
        i_kind <= KIND_PRINT;
        i_char_code <= '0;
        i_pos_row <= '0;
        i_pos_col <= '0;
        i_back_color <= '0;
        i_fore_color <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry 80x25: field extremes, bad positions, wrap and scrolls
        send_command(KIND_PRINT, 8'hFF, 7'd0, 7'd0, 4'hF, 4'hF);   pause_sender(1'b0);
        send_command(KIND_PRINT, 8'h00, 7'd0, 7'd0, 4'h0, 4'h0);   pause_sender(1'b0);
        send_command(KIND_PRINT, NEWLINE_CODE, 7'd0, 7'd0, 4'h5, 4'hA);
        pause_sender(1'b0);
        send_command(KIND_READ, 8'h00, 7'd0, 7'd0, 4'h0, 4'h0);    pause_sender(1'b0);
        send_command(KIND_PUT, 8'h7E, 7'd24, 7'd79, 4'hC, 4'h3);   pause_sender(1'b0);
        send_command(KIND_READ, 8'h00, 7'd24, 7'd79, 4'h0, 4'h0);  pause_sender(1'b0);
        send_command(KIND_READ, 8'h00, 7'd25, 7'd0, 4'h0, 4'h0);   pause_sender(1'b0);
        send_command(KIND_READ, 8'h00, 7'd0, 7'd80, 4'h0, 4'h0);   pause_sender(1'b0);
        send_command(KIND_PUT, 8'h41, 7'd127, 7'd127, 4'hF, 4'hF); pause_sender(1'b0);
        send_command(KIND_SETCUR, 8'h00, 7'd24, 7'd127, 4'h0, 4'h0);
        pause_sender(1'b0);
        send_command(KIND_PRINT, 8'h7A, 7'd0, 7'd0, 4'h2, 4'h9);   pause_sender(1'b0);
        send_command(KIND_READ, 8'h00, 7'd23, 7'd79, 4'h0, 4'h0);  pause_sender(1'b0);
        send_command(KIND_SETCUR, 8'h00, 7'd26, 7'd5, 4'h0, 4'h0); pause_sender(1'b0);
        send_command(KIND_PRINT, NEWLINE_CODE, 7'd0, 7'd0, 4'h0, 4'h0);

        // Zero registers act as a single cell: every print scrolls
        set_geometry(8'd0, 8'd0, 1'b0);
        send_command(KIND_PRINT, 8'h61, 7'd0, 7'd0, 4'h1, 4'h7);   pause_sender(1'b0);
        send_command(KIND_SETCUR, 8'h00, 7'd127, 7'd127, 4'h0, 4'h0);
        pause_sender(1'b0);
        send_command(KIND_PUT, 8'h62, 7'd0, 7'd0, 4'h6, 4'hE);     pause_sender(1'b0);
        send_command(KIND_READ, 8'h00, 7'd0, 7'd0, 4'h0, 4'h0);    pause_sender(1'b0);
        send_command(KIND_READ, 8'h00, 7'd0, 7'd1, 4'h0, 4'h0);

        // Oversized registers act as the full store
        set_geometry(8'hFF, 8'hFF, 1'b0);
        send_command(KIND_PUT, 8'h80, 7'd63, 7'd127, 4'h8, 4'h4);  pause_sender(1'b0);
        send_command(KIND_READ, 8'h00, 7'd63, 7'd127, 4'h0, 4'h0); pause_sender(1'b0);
        send_command(KIND_SETCUR, 8'h00, 7'd63, 7'd127, 4'h0, 4'h0);
        pause_sender(1'b0);
        send_command(KIND_PRINT, 8'h55, 7'd0, 7'd0, 4'hB, 4'hD);

        // Shrink under the cursor so the next print clamps it
        set_geometry(8'd4, 8'd3, 1'b1);
        send_command(KIND_PRINT, 8'h71, 7'd0, 7'd0, 4'h3, 4'h6);   pause_sender(1'b0);
        send_command(KIND_READ, 8'h00, 7'd2, 7'd0, 4'h0, 4'h0);

        // Random phases, each under its own geometry
        while (random_sent < RANDOM_ITEMS) begin
            roomy = ($urandom_range(0, 9) == 0);
            if (roomy) begin
                pick = $urandom_range(0, 2);
                if (pick == 0) begin
                    cols_data = COLS_RESET;
                    rows_data = {1'b0, ROWS_RESET};
                end else if (pick == 1) begin
                    cols_data = 8'd128;
                    rows_data = 8'd64;
                end else begin
                    cols_data = 8'($urandom_range(40, 128));
                    rows_data = 8'($urandom_range(16, 64));
                end
            end else begin
                pick = $urandom_range(0, 9);
                if (pick == 0) cols_data = 8'd0;
                else if (pick == 1) cols_data = 8'd128;
                else if (pick == 2) cols_data = 8'($urandom_range(129, 255));
                else cols_data = 8'($urandom_range(1, 16));
                // wide rows stay short so that scrolls stay cheap
                if (cols_data > 16 || cols_data == 0) rows_data = 8'($urandom_range(0, 4));
                else rows_data = 8'($urandom_range(0, 8));
                rows_data[7] = 1'($urandom_range(0, 1));
            end
            set_geometry(cols_data, rows_data, 1'b0);
            phase_len = roomy ? $urandom_range(20, 40) : $urandom_range(40, 140);
            // trim the last phase to the item count
            if (phase_len > RANDOM_ITEMS - random_sent)
                phase_len = RANDOM_ITEMS - random_sent;
            burst = ($urandom_range(0, 3) == 0);
            repeat (phase_len) begin
                send_random_command(roomy);
                pause_sender(burst);
            end
            random_sent += phase_len;
        end

        // Drain the last beats, then watch for stray ones
        cycle_budget += DRAIN_CYCLES + 100;
        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d commands: %0d prints, %0d cursor moves, %0d puts, %0d reads",
                 kind_sent[0] + kind_sent[1] + kind_sent[2] + kind_sent[3],
                 kind_sent[0], kind_sent[1], kind_sent[2], kind_sent[3]);
        $display("Covered %0d geometries from 1x1 to 128x64; %0d beats checked, %0d scroll-ups",
                 geometries, checked, scrolls);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
